FILE: sv/boxds_pkg.sv
// ----------------------------------------------------------------------------
// boxds_pkg
// Shared widths, register indexes and reciprocal tables of the box average
// downscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package boxds_pkg;

  localparam int CHAN_W  = 8;
  localparam int COORD_W = 12;
  localparam int SUM_W   = 16;
  localparam int RATE_W  = 5;
  localparam int OWID_W  = 11;
  localparam int OHGT_W  = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int RECIP_W    = 17;
  localparam int RECIP_SHIFT = 16;

  localparam logic [RATE_W-1:0] MAX_RATE = 5'd16;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_CROP_LEFT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_TOP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RATE       = 3'd4;

  // floor(2^16 / r) for a rate of 1 to MAX_RATE
  function automatic logic [RECIP_W-1:0] recip_rate(input logic [RATE_W-1:0] r);
    logic [RECIP_W-1:0] m;
    unique case (r)
      5'd1:    m = 17'd65536;
      5'd2:    m = 17'd32768;
      5'd3:    m = 17'd21845;
      5'd4:    m = 17'd16384;
      5'd5:    m = 17'd13107;
      5'd6:    m = 17'd10922;
      5'd7:    m = 17'd9362;
      5'd8:    m = 17'd8192;
      5'd9:    m = 17'd7281;
      5'd10:   m = 17'd6553;
      5'd11:   m = 17'd5957;
      5'd12:   m = 17'd5461;
      5'd13:   m = 17'd5041;
      5'd14:   m = 17'd4681;
      5'd15:   m = 17'd4369;
      5'd16:   m = 17'd4096;
      default: m = 17'd0;
    endcase
    return m;
  endfunction

  // floor(2^16 / (r * r)) for a rate of 1 to MAX_RATE
  function automatic logic [RECIP_W-1:0] recip_square(input logic [RATE_W-1:0] r);
    logic [RECIP_W-1:0] m;
    unique case (r)
      5'd1:    m = 17'd65536;
      5'd2:    m = 17'd16384;
      5'd3:    m = 17'd7281;
      5'd4:    m = 17'd4096;
      5'd5:    m = 17'd2621;
      5'd6:    m = 17'd1820;
      5'd7:    m = 17'd1337;
      5'd8:    m = 17'd1024;
      5'd9:    m = 17'd809;
      5'd10:   m = 17'd655;
      5'd11:   m = 17'd541;
      5'd12:   m = 17'd455;
      5'd13:   m = 17'd387;
      5'd14:   m = 17'd334;
      5'd15:   m = 17'd291;
      5'd16:   m = 17'd256;
      default: m = 17'd0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: sv/boxds_ram.sv
// ----------------------------------------------------------------------------
// boxds_ram
// Simple dual-port RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module boxds_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire             clk,
  input  wire             we,
  input  wire [AW-1:0]    waddr,
  input  wire [WIDTH-1:0] wdata,
  input  wire             re,
  input  wire [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/box_average_downscaler.sv
// ----------------------------------------------------------------------------
// box_average_downscaler
// Crops a region of a raster RGB stream and averages each rate-by-rate square.
// One item at a time: a pixel is taken only when idle; a stalled result holds
// the block. Each pixel passes MUL and FIX, one inside the region also RD and
// MOD, one closing a square also DIV and OUT. The steps are set by the reciprocal
// multiplies and the registered-read row-sum RAM. Reset clears state, counters
// and output valid and loads config defaults; data and sum RAM are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module box_average_downscaler
  import boxds_pkg::*;
#(
  parameter int MAX_OUT_WIDTH = 1024
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire [CHAN_W-1:0]     in_red_in,
  input  wire [CHAN_W-1:0]     in_green_in,
  input  wire [CHAN_W-1:0]     in_blue_in,
  input  wire                  in_end_of_line,
  input  wire                  in_end_of_frame,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [CHAN_W-1:0]    out_red_out,
  output logic [CHAN_W-1:0]    out_green_out,
  output logic [CHAN_W-1:0]    out_blue_out,
  output logic                 out_last_in_row,
  output logic                 out_last_in_frame,
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_DATA_W-1:0] cfg_data
);

  localparam int ADDR_W = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
  localparam int MEM_W  = 3 * SUM_W;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL  = 7'b0000010,
    ST_FIX  = 7'b0000100,
    ST_RD   = 7'b0001000,
    ST_MOD  = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [COORD_W-1:0] crop_left_r, crop_top_r;
  logic [OWID_W-1:0]  out_width_r;
  logic [OHGT_W-1:0]  out_height_r;
  logic [RATE_W-1:0]  rate_r;

  // Source position
  logic [COORD_W-1:0] col_r, row_r;

  // Per-item registers
  logic [CHAN_W-1:0]  pix_r [3];
  logic [COORD_W-1:0] rx_r, ry_r;
  logic               inside_r;
  logic [OWID_W-1:0]  w_r;
  logic [OHGT_W-1:0]  h_r;
  logic [RATE_W-1:0]  r_r;
  logic [COORD_W-1:0] qx0_r, qy0_r;
  logic               region_r;
  logic [8:0]         sq_r;
  logic [COORD_W-1:0] ox_r, oy_r;
  logic [RATE_W-1:0]  sx_r, sy_r;
  logic [SUM_W-1:0]   sum_r [3];
  logic [SUM_W-1:0]   q0_r [3];

  // Output register
  logic               out_valid_r;
  logic [CHAN_W-1:0]  out_pix_r [3];
  logic               out_row_r, out_frame_r;

  // Clamped configuration
  logic [OWID_W-1:0] w_cl;
  logic [OHGT_W-1:0] h_cl;
  logic [RATE_W-1:0] r_cl;

  logic accept, out_load;

  // Datapath nets
  logic [28:0]       prod_x, prod_y;
  logic [15:0]       span_x;
  logic [17:0]       span_y;
  logic [16:0]       rem_x_full, rem_y_full;
  logic [5:0]        rem_x, rem_y;
  logic [COORD_W-1:0] ox_nxt, oy_nxt;
  logic [RATE_W-1:0]  sx_nxt, sy_nxt;
  logic               first_px, last_px;
  logic [SUM_W-1:0]   sum_nxt [3];
  logic [32:0]        prod_q [3];
  logic [24:0]        rem_q_full [3];
  logic [9:0]         rem_q [3];
  logic [SUM_W-1:0]   q_fix [3];
  logic [CHAN_W-1:0]  avg_nxt [3];
  logic               last_row_nxt, last_frame_nxt;

  logic [MEM_W-1:0]  ram_rdata, ram_wdata;
  logic              ram_we, ram_re;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crop_left_r  <= '0;
      crop_top_r   <= '0;
      out_width_r  <= 11'd1;
      out_height_r <= 13'd1;
      rate_r       <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CROP_LEFT:  crop_left_r  <= cfg_data[COORD_W-1:0];
        REG_CROP_TOP:   crop_top_r   <= cfg_data[COORD_W-1:0];
        REG_OUT_WIDTH:  out_width_r  <= cfg_data[OWID_W-1:0];
        REG_OUT_HEIGHT: out_height_r <= cfg_data[OHGT_W-1:0];
        REG_RATE:       rate_r       <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (out_width_r == '0) begin
      w_cl = 11'd1;
    end else if (32'(out_width_r) > MAX_OUT_WIDTH) begin
      w_cl = OWID_W'(MAX_OUT_WIDTH);
    end else begin
      w_cl = out_width_r;
    end
    h_cl = (out_height_r == '0) ? 13'd1 : out_height_r;
    if (rate_r == '0) begin
      r_cl = 5'd1;
    end else if (rate_r > MAX_RATE) begin
      r_cl = MAX_RATE;
    end else begin
      r_cl = rate_r;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_FIX;
      ST_FIX:  state_nxt = region_r ? ST_RD : ST_IDLE;
      ST_RD:   state_nxt = ST_MOD;
      ST_MOD:  state_nxt = last_px ? ST_DIV : ST_IDLE;
      ST_DIV:  state_nxt = ST_OUT;
      ST_OUT:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        priority if (in_end_of_frame) begin
          col_r <= '0;
          row_r <= '0;
        end else if (in_end_of_line) begin
          col_r <= '0;
          row_r <= row_r + 12'd1;
        end else begin
          col_r <= col_r + 12'd1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Position within the region: quotient by reciprocal, then one correction
  // --------------------------------------------------------------------------
  assign prod_x = 29'(rx_r) * 29'(recip_rate(r_r));
  assign prod_y = 29'(ry_r) * 29'(recip_rate(r_r));
  assign span_x = 16'(w_r) * 16'(r_r);
  assign span_y = 18'(h_r) * 18'(r_r);

  assign rem_x_full = 17'(rx_r) - 17'(qx0_r) * 17'(r_r);
  assign rem_y_full = 17'(ry_r) - 17'(qy0_r) * 17'(r_r);
  assign rem_x = rem_x_full[5:0];
  assign rem_y = rem_y_full[5:0];

  always_comb begin
    if (rem_x >= 6'(r_r)) begin
      ox_nxt = qx0_r + 12'd1;
      sx_nxt = 5'(rem_x - 6'(r_r));
    end else begin
      ox_nxt = qx0_r;
      sx_nxt = rem_x[RATE_W-1:0];
    end
    if (rem_y >= 6'(r_r)) begin
      oy_nxt = qy0_r + 12'd1;
      sy_nxt = 5'(rem_y - 6'(r_r));
    end else begin
      oy_nxt = qy0_r;
      sy_nxt = rem_y[RATE_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Row-sum update and averaging
  // --------------------------------------------------------------------------
  assign first_px = (sx_r == '0) && (sy_r == '0);
  assign last_px  = (sx_r == r_r - 5'd1) && (sy_r == r_r - 5'd1);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      // the first pixel of a square overwrites whatever the entry held
      sum_nxt[c] = first_px ? SUM_W'(pix_r[c])
                            : ram_rdata[c*SUM_W +: SUM_W] + SUM_W'(pix_r[c]);
      prod_q[c]     = 33'(sum_r[c]) * 33'(recip_square(r_r));
      rem_q_full[c] = 25'(sum_r[c]) - 25'(q0_r[c]) * 25'(sq_r);
      rem_q[c]      = rem_q_full[c][9:0];
      q_fix[c]      = (rem_q[c] >= 10'(sq_r)) ? q0_r[c] + 16'd1 : q0_r[c];
      avg_nxt[c]    = (q_fix[c] > 16'd255) ? 8'hff : q_fix[c][CHAN_W-1:0];
    end
  end

  assign ram_wdata = {sum_nxt[2], sum_nxt[1], sum_nxt[0]};
  assign ram_we    = (state_r == ST_MOD);
  assign ram_re    = (state_r == ST_RD);

  assign last_row_nxt   = (ox_r == {1'b0, w_r - 11'd1});
  assign last_frame_nxt = last_row_nxt && ({1'b0, oy_r} == h_r - 13'd1);

  boxds_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_OUT_WIDTH)
  ) u_sum_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ox_r[ADDR_W-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ox_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Per-item payload
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          pix_r[0] <= in_red_in;
          pix_r[1] <= in_green_in;
          pix_r[2] <= in_blue_in;
          rx_r     <= col_r - crop_left_r;
          ry_r     <= row_r - crop_top_r;
          inside_r <= (col_r >= crop_left_r) && (row_r >= crop_top_r);
          w_r      <= w_cl;
          h_r      <= h_cl;
          r_r      <= r_cl;
        end
      end
      ST_MUL: begin
        qx0_r    <= prod_x[27:16];
        qy0_r    <= prod_y[27:16];
        region_r <= inside_r && ({4'b0, rx_r} < span_x) && ({6'b0, ry_r} < span_y);
        sq_r     <= 9'(10'(r_r) * 10'(r_r));
      end
      ST_FIX: begin
        ox_r <= ox_nxt;
        oy_r <= oy_nxt;
        sx_r <= sx_nxt;
        sy_r <= sy_nxt;
      end
      ST_MOD: begin
        for (int c = 0; c < 3; c++) begin
          sum_r[c] <= sum_nxt[c];
        end
      end
      ST_DIV: begin
        for (int c = 0; c < 3; c++) begin
          q0_r[c] <= prod_q[c][31:16];
        end
      end
      ST_RD, ST_OUT: ;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register: hold a result until its transfer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pix_r   <= avg_nxt;
      out_row_r   <= last_row_nxt;
      out_frame_r <= last_frame_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_red_out       = out_pix_r[0];
  assign out_green_out     = out_pix_r[1];
  assign out_blue_out      = out_pix_r[2];
  assign out_last_in_row   = out_row_r;
  assign out_last_in_frame = out_frame_r;

endmodule

`default_nettype wire

FILE: sv/boxds_checker.sv
// ----------------------------------------------------------------------------
// boxds_checker
// Port-level checks of the box average downscaler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module boxds_checker
  import boxds_pkg::*;
(
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_ready,
  input wire                  out_valid,
  input wire                  out_ready,
  input wire [CHAN_W-1:0]     out_red_out,
  input wire [CHAN_W-1:0]     out_green_out,
  input wire [CHAN_W-1:0]     out_blue_out,
  input wire                  out_last_in_row,
  input wire                  out_last_in_frame
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red_out)
      && $stable(out_green_out) && $stable(out_blue_out)
      && $stable(out_last_in_row) && $stable(out_last_in_frame))
    else $error("result changed while stalled");

  // the last pixel of a frame also closes its row
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_last_in_frame || out_last_in_row)
    else $error("frame end without row end");

  // reset leaves the block empty and ready
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not empty after reset");

  // one item at a time: no transfer directly after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is at work");

  // a result never appears on the cycle after an input transfer
  a_no_shortcut: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result too early");

endmodule

bind box_average_downscaler boxds_checker u_boxds_checker (.*);

`default_nettype wire
